FILE: design/template_block_lexer_top_macros.svh
// Assertion macros used by the checker file.
`ifndef TEMPLATE_BLOCK_LEXER_TOP_MACROS_SVH
`define TEMPLATE_BLOCK_LEXER_TOP_MACROS_SVH

// Checked at every clock edge outside reset.
`define TBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TBL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbl_pkg;

  localparam int MaxItems   = 3;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic [3:0] KText   = 4'd0;
  localparam logic [3:0] KLat    = 4'd1;
  localparam logic [3:0] KRat    = 4'd2;
  localparam logic [3:0] KLdb    = 4'd3;
  localparam logic [3:0] KRdb    = 4'd4;
  localparam logic [3:0] KIdent  = 4'd5;
  localparam logic [3:0] KStr    = 4'd6;
  localparam logic [3:0] KDot    = 4'd7;
  localparam logic [3:0] KComma  = 4'd8;
  localparam logic [3:0] KLpar   = 4'd9;
  localparam logic [3:0] KRpar   = 4'd10;
  localparam logic [3:0] KStatus = 4'd11;

  localparam logic [1:0] MText = 2'd0;
  localparam logic [1:0] MAt   = 2'd1;
  localparam logic [1:0] MDbl  = 2'd2;

  localparam logic [1:0] PNone   = 2'd0;
  localparam logic [1:0] PLbrace = 2'd1;
  localparam logic [1:0] PRbrace = 2'd2;
  localparam logic [1:0] PAt     = 2'd3;

  localparam logic [1:0] ONone  = 2'd0;
  localparam logic [1:0] OIdent = 2'd1;
  localparam logic [1:0] OStr   = 2'd2;
  localparam logic [1:0] OEsc   = 2'd3;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrLoneAt   = 3'd1;
  localparam logic [2:0] ErrBadChar  = 3'd2;
  localparam logic [2:0] ErrNewline  = 3'd3;
  localparam logic [2:0] ErrUnclosed = 3'd4;

  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef logic [QPtrW-1:0] qptr_t;
  typedef logic [QPtrW:0]   qcount_t;

  typedef struct packed {
    logic [3:0] tok_kind;
    logic [7:0] content_byte;
    logic       byte_valid;
    logic       tok_first;
    logic       tok_end;
    logic [2:0] err_code;
    logic       src_done;
  } item_t;

  typedef struct packed {
    item_t [MaxItems-1:0] items;
    logic  [1:0]          count;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } push_t;

  typedef struct packed {
    logic    valid;
    bundle_t head;
  } head_t;

  function automatic item_t mk_item(logic [3:0] kind, logic [7:0] data, logic bv,
                                    logic first, logic fin, logic [2:0] err,
                                    logic done);
    item_t it;
    it.tok_kind     = kind;
    it.content_byte = bv ? data : 8'd0;
    it.byte_valid   = bv;
    it.tok_first    = first;
    it.tok_end      = fin;
    it.err_code     = err;
    it.src_done     = done;
    return it;
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == ChUscore;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == ChSpace || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

`default_nettype wire

FILE: design/tbl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tbl_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_mark;

  modport source (output valid, output src_byte, output end_mark, input ready);
  modport sink (input valid, input src_byte, input end_mark, output ready);
endinterface

interface tbl_tok_if;
  logic       valid;
  logic       ready;
  logic [3:0] tok_kind;
  logic [7:0] content_byte;
  logic       byte_valid;
  logic       tok_first;
  logic       tok_end;
  logic [2:0] err_code;
  logic       src_done;
  logic       run_last;

  modport source (output valid, output tok_kind, output content_byte,
                  output byte_valid, output tok_first, output tok_end,
                  output err_code, output src_done, output run_last, input ready);
  modport sink (input valid, input tok_kind, input content_byte,
                input byte_valid, input tok_first, input tok_end,
                input err_code, input src_done, input run_last, output ready);
endinterface

`default_nettype wire

FILE: design/template_block_lexer_top.sv
// Channel  Dir  Payload                                         Beat when
// src      in   src_byte[8], end_mark                           src.valid && src.ready
// tok      out  tok_kind[4], content_byte[8], byte_valid,       tok.valid && tok.ready
//               tok_first, tok_end, err_code[3], src_done, run_last
//
// The front takes one source beat per cycle while the queue has room; each makes up to 3 tokens.
// A four-entry bundle queue sits between front and back; src.ready drops only when it is full.
// The back sends one token beat per cycle unless tok.ready stalls it, a bundle's tokens in turn.
// After its source beat a token is registered in the queue, then in the output register.
// Reset is synchronous and clears lexer state, the queue and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module template_block_lexer_top (
  input  wire logic clk,
  input  wire logic rst,
  tbl_src_if.sink   src,
  tbl_tok_if.source tok
);

  tbl_pkg::push_t push;
  tbl_pkg::head_t head;
  logic           q_ready;
  logic           pop;

  tbl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .src     (src),
    .q_ready (q_ready),
    .push    (push)
  );

  tbl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .pop   (pop),
    .head  (head)
  );

  tbl_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .tok  (tok)
  );

endmodule

`default_nettype wire

FILE: design/tbl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbl_front (
  input  wire logic    clk,
  input  wire logic    rst,
  tbl_src_if.sink      src,
  input  wire logic    q_ready,
  output tbl_pkg::push_t push
);

  logic [1:0] lex_mode, lex_mode_next;
  logic [1:0] pending_char, pending_char_next;
  logic [1:0] open_token, open_token_next;
  logic       text_open, text_open_next;
  logic       string_nonempty, string_nonempty_next;
  logic       halted_on_error, halted_on_error_next;

  tbl_pkg::bundle_t b;
  logic [1:0]       n;
  logic             go;
  logic [1:0]       p;
  logic [7:0]       c;
  logic             take;

  assign take = src.valid && q_ready;
  assign src.ready = q_ready;
  assign c = src.src_byte;

  always_comb begin
    lex_mode_next        = lex_mode;
    pending_char_next    = pending_char;
    open_token_next      = open_token;
    text_open_next       = text_open;
    string_nonempty_next = string_nonempty;
    halted_on_error_next = halted_on_error;
    b  = '0;
    n  = 2'd0;
    go = 1'b1;
    p  = tbl_pkg::PNone;

    if (src.end_mark) begin
      if (!halted_on_error) begin
        if (lex_mode == tbl_pkg::MText) begin
          if (pending_char == tbl_pkg::PLbrace) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KText, tbl_pkg::ChLbrace, 1'b1,
                                          !text_open_next, 1'b0, tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
            text_open_next = 1'b1;
          end
          if (text_open_next) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KText, 8'd0, 1'b0, 1'b0, 1'b1,
                                          tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
          end
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                        tbl_pkg::ErrNone, 1'b1);
          n = n + 2'd1;
        end else begin
          if (open_token == tbl_pkg::OIdent) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KIdent, 8'd0, 1'b0, 1'b0, 1'b1,
                                          tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
          end else if (open_token == tbl_pkg::OStr || open_token == tbl_pkg::OEsc) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStr, 8'd0, 1'b0, !string_nonempty,
                                          1'b1, tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
          end
          if (pending_char == tbl_pkg::PAt) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                          tbl_pkg::ErrLoneAt, 1'b1);
          end else if (pending_char == tbl_pkg::PRbrace) begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                          tbl_pkg::ErrBadChar, 1'b1);
          end else begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                          tbl_pkg::ErrUnclosed, 1'b1);
          end
          n = n + 2'd1;
        end
      end
      lex_mode_next        = tbl_pkg::MText;
      pending_char_next    = tbl_pkg::PNone;
      open_token_next      = tbl_pkg::ONone;
      text_open_next       = 1'b0;
      string_nonempty_next = 1'b0;
      halted_on_error_next = 1'b0;
    end else if (!halted_on_error) begin
      if (open_token == tbl_pkg::OEsc) begin
        b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStr, c, 1'b1, !string_nonempty, 1'b0,
                                      tbl_pkg::ErrNone, 1'b0);
        n = n + 2'd1;
        string_nonempty_next = 1'b1;
        open_token_next = tbl_pkg::OStr;
        go = 1'b0;
      end else if (open_token == tbl_pkg::OStr) begin
        if (c == tbl_pkg::ChQuote) begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStr, 8'd0, 1'b0, !string_nonempty, 1'b1,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
          open_token_next = tbl_pkg::ONone;
          string_nonempty_next = 1'b0;
        end else if (c == tbl_pkg::ChBslash) begin
          open_token_next = tbl_pkg::OEsc;
        end else begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStr, c, 1'b1, !string_nonempty, 1'b0,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
          string_nonempty_next = 1'b1;
        end
        go = 1'b0;
      end else if (pending_char != tbl_pkg::PNone) begin
        p = pending_char;
        pending_char_next = tbl_pkg::PNone;
        if (p == tbl_pkg::PLbrace) begin
          if (c == tbl_pkg::ChAt || c == tbl_pkg::ChLbrace) begin
            if (text_open) begin
              b.items[n] = tbl_pkg::mk_item(tbl_pkg::KText, 8'd0, 1'b0, 1'b0, 1'b1,
                                            tbl_pkg::ErrNone, 1'b0);
              n = n + 2'd1;
            end
            text_open_next = 1'b0;
            b.items[n] = tbl_pkg::mk_item((c == tbl_pkg::ChAt) ? tbl_pkg::KLat :
                                          tbl_pkg::KLdb, 8'd0, 1'b0, 1'b1, 1'b1,
                                          tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
            lex_mode_next = (c == tbl_pkg::ChAt) ? tbl_pkg::MAt : tbl_pkg::MDbl;
            go = 1'b0;
          end else begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KText, tbl_pkg::ChLbrace, 1'b1,
                                          !text_open, 1'b0, tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
            text_open_next = 1'b1;
          end
        end else begin
          if (c == tbl_pkg::ChRbrace) begin
            b.items[n] = tbl_pkg::mk_item((p == tbl_pkg::PAt) ? tbl_pkg::KRat :
                                          tbl_pkg::KRdb, 8'd0, 1'b0, 1'b1, 1'b1,
                                          tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
            lex_mode_next = tbl_pkg::MText;
          end else begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                          (p == tbl_pkg::PAt) ? tbl_pkg::ErrLoneAt :
                                          tbl_pkg::ErrBadChar, 1'b1);
            n = n + 2'd1;
            lex_mode_next        = tbl_pkg::MText;
            open_token_next      = tbl_pkg::ONone;
            text_open_next       = 1'b0;
            string_nonempty_next = 1'b0;
            halted_on_error_next = 1'b1;
          end
          go = 1'b0;
        end
      end else if (open_token == tbl_pkg::OIdent) begin
        if (tbl_pkg::is_ident(c)) begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KIdent, c, 1'b1, 1'b0, 1'b0,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
          go = 1'b0;
        end else begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KIdent, 8'd0, 1'b0, 1'b0, 1'b1,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
          open_token_next = tbl_pkg::ONone;
          string_nonempty_next = 1'b0;
        end
      end

      if (go) begin
        if (lex_mode_next == tbl_pkg::MText) begin
          if (c == tbl_pkg::ChLbrace) begin
            pending_char_next = tbl_pkg::PLbrace;
          end else begin
            b.items[n] = tbl_pkg::mk_item(tbl_pkg::KText, c, 1'b1, !text_open_next, 1'b0,
                                          tbl_pkg::ErrNone, 1'b0);
            n = n + 2'd1;
            text_open_next = 1'b1;
          end
        end else if (c == tbl_pkg::ChQuote) begin
          open_token_next = tbl_pkg::OStr;
          string_nonempty_next = 1'b0;
        end else if (tbl_pkg::is_ident(c)) begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KIdent, c, 1'b1, 1'b1, 1'b0,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
          open_token_next = tbl_pkg::OIdent;
        end else if (c == tbl_pkg::ChDot || c == tbl_pkg::ChComma ||
                     c == tbl_pkg::ChLpar || c == tbl_pkg::ChRpar) begin
          b.items[n] = tbl_pkg::mk_item((c == tbl_pkg::ChDot) ? tbl_pkg::KDot :
                                        (c == tbl_pkg::ChComma) ? tbl_pkg::KComma :
                                        (c == tbl_pkg::ChLpar) ? tbl_pkg::KLpar :
                                        tbl_pkg::KRpar, 8'd0, 1'b0, 1'b1, 1'b1,
                                        tbl_pkg::ErrNone, 1'b0);
          n = n + 2'd1;
        end else if (lex_mode_next == tbl_pkg::MAt && c == tbl_pkg::ChAt) begin
          pending_char_next = tbl_pkg::PAt;
        end else if (lex_mode_next == tbl_pkg::MDbl && c == tbl_pkg::ChRbrace) begin
          pending_char_next = tbl_pkg::PRbrace;
        end else if (!(tbl_pkg::is_space(c) &&
                       !(lex_mode_next == tbl_pkg::MDbl && c == tbl_pkg::ChNl))) begin
          b.items[n] = tbl_pkg::mk_item(tbl_pkg::KStatus, 8'd0, 1'b0, 1'b0, 1'b0,
                                        (lex_mode_next == tbl_pkg::MDbl &&
                                         c == tbl_pkg::ChNl) ? tbl_pkg::ErrNewline :
                                        tbl_pkg::ErrBadChar, 1'b1);
          n = n + 2'd1;
          lex_mode_next        = tbl_pkg::MText;
          pending_char_next    = tbl_pkg::PNone;
          open_token_next      = tbl_pkg::ONone;
          text_open_next       = 1'b0;
          string_nonempty_next = 1'b0;
          halted_on_error_next = 1'b1;
        end
      end
    end
    b.count = n;
  end

  assign push.push   = take && (n != 2'd0);
  assign push.bundle = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode        <= tbl_pkg::MText;
      pending_char    <= tbl_pkg::PNone;
      open_token      <= tbl_pkg::ONone;
      text_open       <= 1'b0;
      string_nonempty <= 1'b0;
      halted_on_error <= 1'b0;
    end else if (take) begin
      lex_mode        <= lex_mode_next;
      pending_char    <= pending_char_next;
      open_token      <= open_token_next;
      text_open       <= text_open_next;
      string_nonempty <= string_nonempty_next;
      halted_on_error <= halted_on_error_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/tbl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tbl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  tbl_pkg::push_t      push,
  output logic                ready,
  input  wire logic           pop,
  output tbl_pkg::head_t      head
);

  tbl_pkg::bundle_t mem [tbl_pkg::QueueDepth];
  tbl_pkg::qptr_t   wr_ptr;
  tbl_pkg::qptr_t   rd_ptr;
  tbl_pkg::qcount_t count;
  logic             do_push;
  logic             do_pop;

  assign ready   = (count != tbl_pkg::qcount_t'(tbl_pkg::QueueDepth));
  assign do_push = push.push && ready;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + tbl_pkg::qptr_t'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + tbl_pkg::qptr_t'(1);
      end
      count <= count + tbl_pkg::qcount_t'(do_push) - tbl_pkg::qcount_t'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: design/tbl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbl_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  tbl_pkg::head_t head,
  output logic           pop,
  tbl_tok_if.source      tok
);

  logic [1:0]     idx;
  logic           last;
  logic           load;
  logic           out_valid;
  tbl_pkg::item_t out_item;
  logic           out_last;
  tbl_pkg::item_t cur;

  assign cur  = head.head.items[idx];
  assign last = (idx == head.head.count - 2'd1);
  assign load = head.valid && (!out_valid || tok.ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= cur;
      out_last <= last;
    end
  end

  assign tok.valid        = out_valid;
  assign tok.tok_kind     = out_item.tok_kind;
  assign tok.content_byte = out_item.content_byte;
  assign tok.byte_valid   = out_item.byte_valid;
  assign tok.tok_first    = out_item.tok_first;
  assign tok.tok_end      = out_item.tok_end;
  assign tok.err_code     = out_item.err_code;
  assign tok.src_done     = out_item.src_done;
  assign tok.run_last     = out_last;

endmodule

`default_nettype wire

FILE: design/tbl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "template_block_lexer_top_macros.svh"

module tbl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       tok_valid,
  input wire logic       tok_ready,
  input wire logic [3:0] tok_kind,
  input wire logic [7:0] content_byte,
  input wire logic       byte_valid,
  input wire logic       src_done,
  input wire logic       run_last
);

  `TBL_ASSERT(a_hold, tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind), "tok beat dropped while stalled")
  `TBL_ASSERT(a_done_last, tok_valid && src_done |-> run_last, "status token is not last of its run")
  `TBL_ASSERT(a_status_kind, tok_valid |-> ((tok_kind == tbl_pkg::KStatus) == src_done), "status kind and src_done disagree")
  `TBL_ASSERT(a_empty_byte, tok_valid && !byte_valid |-> content_byte == 8'd0, "content byte set without byte_valid")
  `TBL_ASSERT_ALWAYS(a_reset_idle, rst |=> !tok_valid, "tok valid right after reset")

endmodule

bind template_block_lexer_top tbl_checker u_tbl_checker (
  .clk          (clk),
  .rst          (rst),
  .tok_valid    (tok.valid),
  .tok_ready    (tok.ready),
  .tok_kind     (tok.tok_kind),
  .content_byte (tok.content_byte),
  .byte_valid   (tok.byte_valid),
  .src_done     (tok.src_done),
  .run_last     (tok.run_last)
);

`default_nettype wire
